>>> rtl/hsvi_pkg.sv
// HSV colour interpolator: shared types and fixed-point constants.
// Depends on nothing; the front, queue, back and top-level files use it.
package hsvi_pkg;

  // One in Q1.16
  localparam logic [16:0] ONE_FX = 17'h10000;
  // Hue of black: minus one degree in sixths of a turn, Q.16
  localparam logic signed [19:0] BLACK_HUE = -20'sd1092;
  // One full turn in hue units
  localparam logic signed [19:0] FULL_TURN = 20'sd393216;
  // Last hue sector
  localparam logic [2:0] SECTOR_LAST = 3'd5;

  // Which channel holds the maximum
  localparam logic [1:0] TOP_RED   = 2'd0;
  localparam logic [1:0] TOP_GREEN = 2'd1;
  localparam logic [1:0] TOP_BLUE  = 2'd2;

  // Classified colour: everything the HSV conversion needs
  typedef struct packed {
    logic [7:0] hi;     // max component
    logic [7:0] span;   // max - min
    logic [7:0] num;    // magnitude of the sector difference
    logic       neg;    // sector difference is negative
    logic [1:0] top;    // channel that holds the max
    logic       black;  // max is zero
    logic       grey;   // max equals min
  } col_t;

  // One queued transaction
  typedef struct packed {
    logic       bypass;
    logic [7:0] byp_red;
    logic [7:0] byp_green;
    logic [7:0] byp_blue;
    logic [7:0] wt;
    col_t       c0;
    col_t       c1;
  } desc_t;

endpackage

>>> rtl/hsvi_if.sv
// HSV colour interpolator: valid/ready channel interfaces.
// Depends on nothing.
interface hsvi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] start_red;
  logic [7:0] start_green;
  logic [7:0] start_blue;
  logic [7:0] end_red;
  logic [7:0] end_green;
  logic [7:0] end_blue;
  logic [7:0] blend_amount;

  modport source (output valid, start_red, start_green, start_blue, end_red, end_green,
                  end_blue, blend_amount, input ready);
  modport sink (input valid, start_red, start_green, start_blue, end_red, end_green,
                end_blue, blend_amount, output ready);
endinterface

interface hsvi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

>>> rtl/hsvi_front.sv
// HSV colour interpolator: input side, accepts and classifies transactions.
// Depends on hsvi_pkg and hsvi_in_if.
module hsvi_front (
  hsvi_in_if.sink         in_i,
  input  logic            full_i,
  output logic            push_o,
  output hsvi_pkg::desc_t desc_o
);

  function automatic hsvi_pkg::col_t classify(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    hsvi_pkg::col_t c;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [8:0] d;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    c.hi    = hi;
    c.span  = hi - lo;
    c.black = (hi == 8'd0);
    c.grey  = (hi == lo);
    // Pick the sector by the channel that holds the max
    if (r == hi) begin
      c.top = hsvi_pkg::TOP_RED;
      d     = {1'b0, g} - {1'b0, b};
    end else if (g == hi) begin
      c.top = hsvi_pkg::TOP_GREEN;
      d     = {1'b0, b} - {1'b0, r};
    end else begin
      c.top = hsvi_pkg::TOP_BLUE;
      d     = {1'b0, r} - {1'b0, g};
    end
    c.neg = d[8];
    c.num = d[8] ? 8'(-d) : d[7:0];
    return c;
  endfunction

  // Accept whenever the queue has room
  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  // Classify both colours and the end-point weights
  always_comb begin
    desc_o.wt     = in_i.blend_amount;
    desc_o.bypass = (in_i.blend_amount == 8'd0) || (in_i.blend_amount == 8'hFF);
    if (in_i.blend_amount == 8'd0) begin
      desc_o.byp_red   = in_i.start_red;
      desc_o.byp_green = in_i.start_green;
      desc_o.byp_blue  = in_i.start_blue;
    end else begin
      desc_o.byp_red   = in_i.end_red;
      desc_o.byp_green = in_i.end_green;
      desc_o.byp_blue  = in_i.end_blue;
    end
    desc_o.c0 = classify(in_i.start_red, in_i.start_green, in_i.start_blue);
    desc_o.c1 = classify(in_i.end_red, in_i.end_green, in_i.end_blue);
  end

endmodule

>>> rtl/hsvi_fifo.sv
// HSV colour interpolator: short queue between the front and back parts.
// Depends on hsvi_pkg.
module hsvi_fifo #(
  parameter int Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hsvi_pkg::desc_t desc_i,
  input  logic            pop_i,
  output hsvi_pkg::desc_t head_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  hsvi_pkg::desc_t mem_q [Depth];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] p);
    return (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= desc_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wrap_inc(wr_q);
      if (pop_i) rd_q <= wrap_inc(rd_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

>>> rtl/hsvi_div.sv
// HSV colour interpolator: pipelined divider, num * 2^16 / den with num <= den.
// Depends on nothing; four bits of quotient per stage, NumStages registered stages.
module hsvi_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [7:0]  num_i,
  input  logic [7:0]  den_i,
  output logic [16:0] quo_o
);

  localparam int NumStages = 4;
  localparam int Steps     = 4;

  logic [7:0]  rem_q [NumStages];
  logic [16:0] quo_q [NumStages];
  logic [7:0]  den_q [NumStages];
  logic [7:0]  rem_src [NumStages];
  logic [16:0] quo_src [NumStages];
  logic [7:0]  den_src [NumStages];

  // First quotient bit: num / den is 0 or 1
  assign rem_src[0] = (num_i >= den_i) ? num_i - den_i : num_i;
  assign quo_src[0] = {16'd0, (num_i >= den_i)};
  assign den_src[0] = den_i;

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    logic [7:0]  rem_d;
    logic [16:0] quo_d;

    if (s > 0) begin : g_link
      assign rem_src[s] = rem_q[s-1];
      assign quo_src[s] = quo_q[s-1];
      assign den_src[s] = den_q[s-1];
    end

    // Shift in zero bits and subtract where it fits
    always_comb begin
      logic [8:0] r2;
      rem_d = rem_src[s];
      quo_d = quo_src[s];
      for (int i = 0; i < Steps; i++) begin
        r2 = {rem_d, 1'b0};
        if (r2 >= {1'b0, den_src[s]}) begin
          rem_d = 8'(r2 - {1'b0, den_src[s]});
          quo_d = {quo_d[15:0], 1'b1};
        end else begin
          rem_d = r2[7:0];
          quo_d = {quo_d[15:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
        den_q[s] <= den_src[s];
      end
    end
  end

  assign quo_o = quo_q[NumStages-1];

endmodule

>>> rtl/hsvi_back.sv
// HSV colour interpolator: back part, HSV conversion, blend and return to RGB.
// Depends on hsvi_pkg, hsvi_div and hsvi_out_if.
module hsvi_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hsvi_pkg::desc_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  hsvi_out_if.source      out_o
);

  localparam int DivLat = 4;

  logic adv;
  logic [16:0] sat0_quo, sat1_quo, rat0_quo, rat1_quo;

  // Whole pipeline moves when the output register is free or being taken
  assign adv   = !out_o.valid || out_o.ready;
  assign pop_o = adv && !empty_i;

  // Saturation and hue ratio for both colours
  hsvi_div u_sat0 (.clk_i, .en_i(adv), .num_i(head_i.c0.span), .den_i(head_i.c0.hi),
                   .quo_o(sat0_quo));
  hsvi_div u_rat0 (.clk_i, .en_i(adv), .num_i(head_i.c0.num), .den_i(head_i.c0.span),
                   .quo_o(rat0_quo));
  hsvi_div u_sat1 (.clk_i, .en_i(adv), .num_i(head_i.c1.span), .den_i(head_i.c1.hi),
                   .quo_o(sat1_quo));
  hsvi_div u_rat1 (.clk_i, .en_i(adv), .num_i(head_i.c1.num), .den_i(head_i.c1.span),
                   .quo_o(rat1_quo));

  // Carry the transaction alongside the dividers
  logic            dv_q [DivLat];
  hsvi_pkg::desc_t dd_q [DivLat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivLat; i++) dv_q[i] <= 1'b0;
    end else if (adv) begin
      dv_q[0] <= !empty_i;
      for (int i = 1; i < DivLat; i++) dv_q[i] <= dv_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dd_q[0] <= head_i;
      for (int i = 1; i < DivLat; i++) dd_q[i] <= dd_q[i-1];
    end
  end

  function automatic logic signed [19:0] hue_of(hsvi_pkg::col_t c, logic [16:0] rat);
    logic signed [19:0] base;
    logic signed [19:0] r;
    logic signed [19:0] h;
    base = signed'({1'b0, c.top, 17'd0});
    r    = signed'({3'd0, rat});
    h    = c.neg ? base - r : base + r;
    if (c.black) h = hsvi_pkg::BLACK_HUE;
    else if (c.grey) h = '0;
    else if (h < 0) h = h + hsvi_pkg::FULL_TURN;
    return h;
  endfunction

  function automatic logic [16:0] val_of(logic [7:0] hi);
    return ({1'b0, hi, 8'd0} + {9'd0, hi}) + {16'd0, (hi == 8'hFF)};
  endfunction

  function automatic logic signed [20:0] lerp(logic signed [20:0] a0, logic signed [20:0] a1,
                                              logic [15:0] wt);
    logic signed [20:0] diff;
    logic [19:0] mag;
    logic [35:0] prod;
    logic signed [20:0] part;
    diff = a1 - a0;
    mag  = diff[20] ? 20'(-diff) : diff[19:0];
    prod = mag * wt;
    part = signed'({1'b0, prod[35:16]});
    return diff[20] ? a0 - part : a0 + part;
  endfunction

  function automatic logic [7:0] to_byte(logic [16:0] c);
    logic [24:0] m;
    m = {c, 8'd0} - {8'd0, c};
    return m[23:16];
  endfunction

  // Stage H: hue, saturation and value of both colours
  logic               hv_q;
  logic signed [19:0] h0_q, h1_q;
  logic [16:0]        s0_q, s1_q, v0_q, v1_q;
  logic [15:0]        wt_q;
  logic               hbyp_q;
  logic [23:0]        hrgb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) hv_q <= 1'b0;
    else if (adv) hv_q <= dv_q[DivLat-1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h0_q   <= hue_of(dd_q[DivLat-1].c0, rat0_quo);
      h1_q   <= hue_of(dd_q[DivLat-1].c1, rat1_quo);
      s0_q   <= dd_q[DivLat-1].c0.black ? '0 : sat0_quo;
      s1_q   <= dd_q[DivLat-1].c1.black ? '0 : sat1_quo;
      v0_q   <= val_of(dd_q[DivLat-1].c0.hi);
      v1_q   <= val_of(dd_q[DivLat-1].c1.hi);
      wt_q   <= {dd_q[DivLat-1].wt, 8'd0} + {8'd0, dd_q[DivLat-1].wt};
      hbyp_q <= dd_q[DivLat-1].bypass;
      hrgb_q <= {dd_q[DivLat-1].byp_red, dd_q[DivLat-1].byp_green, dd_q[DivLat-1].byp_blue};
    end
  end

  // Stage L: blend the three components
  logic               lv_q;
  logic signed [19:0] lh_q;
  logic [16:0]        ls_q, lvl_q;
  logic               lbyp_q;
  logic [23:0]        lrgb_q;
  logic signed [20:0] lh_d, ls_d, lvl_d;

  assign lh_d  = lerp(21'(h0_q), 21'(h1_q), wt_q);
  assign ls_d  = lerp(signed'({4'd0, s0_q}), signed'({4'd0, s1_q}), wt_q);
  assign lvl_d = lerp(signed'({4'd0, v0_q}), signed'({4'd0, v1_q}), wt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) lv_q <= 1'b0;
    else if (adv) lv_q <= hv_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lh_q   <= lh_d[19:0];
      ls_q   <= ls_d[16:0];
      lvl_q  <= lvl_d[16:0];
      lbyp_q <= hbyp_q;
      lrgb_q <= hrgb_q;
    end
  end

  // Stage R1: sector, fraction and the first products
  logic        r1v_q;
  logic [2:0]  r1sec_q;
  logic [16:0] sf_q, sg_q, p1_q, r1v_val_q, r1s_q;
  logic        r1byp_q;
  logic [23:0] r1rgb_q;
  logic [2:0]  sec_d;
  logic [15:0] frac_d;
  logic [19:0] hplus;
  logic [32:0] sf_prod;
  logic [33:0] sg_prod, p_prod;

  always_comb begin
    hplus = 20'(lh_q) + 20'h10000;
    if (lh_q[19]) begin
      sec_d  = hsvi_pkg::SECTOR_LAST;
      frac_d = hplus[15:0];
    end else begin
      sec_d  = (lh_q[18:16] > hsvi_pkg::SECTOR_LAST) ? hsvi_pkg::SECTOR_LAST : lh_q[18:16];
      frac_d = lh_q[15:0];
    end
    sf_prod = ls_q * frac_d;
    sg_prod = ls_q * (hsvi_pkg::ONE_FX - {1'b0, frac_d});
    p_prod  = lvl_q * (hsvi_pkg::ONE_FX - ls_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) r1v_q <= 1'b0;
    else if (adv) r1v_q <= lv_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r1sec_q   <= sec_d;
      sf_q      <= sf_prod[32:16];
      sg_q      <= sg_prod[32:16];
      p1_q      <= p_prod[32:16];
      r1v_val_q <= lvl_q;
      r1s_q     <= ls_q;
      r1byp_q   <= lbyp_q;
      r1rgb_q   <= lrgb_q;
    end
  end

  // Stage R2: q and t
  logic        r2v_q;
  logic [2:0]  r2sec_q;
  logic [16:0] q2_q, t2_q, p2_q, r2v_val_q;
  logic        r2zero_q;
  logic        r2byp_q;
  logic [23:0] r2rgb_q;
  logic [33:0] q_prod, t_prod;

  assign q_prod = r1v_val_q * (hsvi_pkg::ONE_FX - sf_q);
  assign t_prod = r1v_val_q * (hsvi_pkg::ONE_FX - sg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) r2v_q <= 1'b0;
    else if (adv) r2v_q <= r1v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r2sec_q   <= r1sec_q;
      q2_q      <= q_prod[32:16];
      t2_q      <= t_prod[32:16];
      p2_q      <= p1_q;
      r2v_val_q <= r1v_val_q;
      r2zero_q  <= (r1s_q == '0);
      r2byp_q   <= r1byp_q;
      r2rgb_q   <= r1rgb_q;
    end
  end

  // Output register: bypass colour or components by sector, scaled to bytes
  logic [16:0] cr, cg, cb;
  logic [7:0]  red_d, green_d, blue_d;
  logic        out_valid_q;
  logic [7:0]  red_q, green_q, blue_q;

  always_comb begin
    unique case (r2sec_q)
      3'd0:    begin cr = r2v_val_q; cg = t2_q;      cb = p2_q;      end
      3'd1:    begin cr = q2_q;      cg = r2v_val_q; cb = p2_q;      end
      3'd2:    begin cr = p2_q;      cg = r2v_val_q; cb = t2_q;      end
      3'd3:    begin cr = p2_q;      cg = q2_q;      cb = r2v_val_q; end
      3'd4:    begin cr = t2_q;      cg = p2_q;      cb = r2v_val_q; end
      default: begin cr = r2v_val_q; cg = p2_q;      cb = q2_q;      end
    endcase
    if (r2byp_q) begin
      red_d   = r2rgb_q[23:16];
      green_d = r2rgb_q[15:8];
      blue_d  = r2rgb_q[7:0];
    end else if (r2zero_q) begin
      red_d   = to_byte(r2v_val_q);
      green_d = to_byte(r2v_val_q);
      blue_d  = to_byte(r2v_val_q);
    end else begin
      red_d   = to_byte(cr);
      green_d = to_byte(cg);
      blue_d  = to_byte(cb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= r2v_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_red   = red_q;
  assign out_o.out_green = green_q;
  assign out_o.out_blue  = blue_q;

endmodule

>>> rtl/hsv_color_interpolator.sv
// HSV colour interpolator, top level: one blended colour per transaction.
// Depends on hsvi_pkg, hsvi_if, hsvi_front, hsvi_fifo and hsvi_back.
//
// Takes one transaction per clock and returns one blended colour per clock in
// steady state when the output is not stalled. A transaction is classified on
// arrival (max, min, sector) and queued in a QueueDepth-entry queue; the back
// pipeline then spends four stages in its bit-per-step dividers (saturation
// and hue ratio), then one stage each for HSV assembly, blending, two rounds
// of products, and the output register. A stalled output holds the back
// pipeline, while the input keeps accepting until the queue is full.
module hsv_color_interpolator #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hsvi_in_if.sink     in_i,
  hsvi_out_if.source  out_o
);

  hsvi_pkg::desc_t desc, head;
  logic            push, pop, full, empty;

  hsvi_front u_front (
    .in_i,
    .full_i (full),
    .push_o (push),
    .desc_o (desc)
  );

  hsvi_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .desc_i  (desc),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  hsvi_back u_back (
    .clk_i,
    .rst_ni,
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o
  );

endmodule

>>> dv/hsvi_tb_if.sv
// Testbench copy point for the channel interfaces: none needed, interfaces come from rtl.
// Depends on nothing; holds the sender/receiver idle pattern helper package.
`timescale 1ns / 1ps
package hsvi_tb_pkg;
  // Idle with a chance of 14 in a hundred unless quiet mode is on
  function automatic bit want_idle(bit quiet);
    return !quiet && ($urandom_range(99, 0) < 14);
  endfunction
endpackage

>>> dv/hsvi_checker.sv
// Checker for the HSV colour interpolator: predicts blends and compares results.
// Depends on hsvi_pkg and the hsvi_in_if / hsvi_out_if interfaces.
`timescale 1ns / 1ps
module hsvi_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsvi_in_if         in_i,
  hsvi_out_if        out_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         blends_seen_o
);
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  rgb_t expected_colours[$];
  int   fail_count;
  int   blends_seen;
  int   pending;

  assign fail_count_o  = fail_count;
  assign pending_o     = pending;
  assign blends_seen_o = blends_seen;

  // Linear blend in fixed point, truncating the step toward zero
  function automatic longint blend_fx(longint a0, longint a1, longint wt);
    longint diff;
    longint part;
    diff = a1 - a0;
    part = (((diff < 0) ? -diff : diff) * wt) >>> 16;
    return (diff < 0) ? a0 - part : a0 + part;
  endfunction

  // Colour to hue, saturation and value
  function automatic void colour_to_hsv(input longint r, input longint g, input longint b,
                                        output longint h, output longint s,
                                        output longint v);
    longint hi;
    longint lo;
    longint span;
    longint num;
    longint quo;
    hi = r; lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    v = (hi * 65536) / 255;
    h = 0;
    s = 0;
    if (hi == 0) begin
      h = hsvi_pkg::BLACK_HUE;
      return;
    end
    span = hi - lo;
    s = (span * 65536) / hi;
    if (span == 0) return;
    if (r == hi) num = g - b;
    else if (g == hi) num = b - r;
    else num = r - g;
    quo = (((num < 0) ? -num : num) * 65536) / span;
    if (num < 0) quo = -quo;
    if (r == hi) h = quo;
    else if (g == hi) h = 2 * 65536 + quo;
    else h = 4 * 65536 + quo;
    if (h < 0) h += hsvi_pkg::FULL_TURN;
  endfunction

  function automatic logic [7:0] to_byte(longint c);
    return 8'((c * 255) >>> 16);
  endfunction

  // Predict one blended colour
  function automatic rgb_t predict_blend(rgb_t c0, rgb_t c1, logic [7:0] amount);
    longint h0, s0, v0, h1, s1, v1, wt, h, s, v, f, sec, p, q, t;
    rgb_t res;
    if (amount == 8'd0) return c0;
    if (amount == 8'd255) return c1;
    colour_to_hsv(c0.red, c0.green, c0.blue, h0, s0, v0);
    colour_to_hsv(c1.red, c1.green, c1.blue, h1, s1, v1);
    wt = (longint'(amount) * 65536) / 255;
    h = blend_fx(h0, h1, wt);
    s = blend_fx(s0, s1, wt);
    v = blend_fx(v0, v1, wt);
    if (s == 0) begin
      res.red = to_byte(v); res.green = res.red; res.blue = res.red;
      return res;
    end
    if (h < 0) begin
      sec = 5; f = h + 65536;
    end else begin
      sec = h >>> 16; f = h & 16'hFFFF;
      if (sec > 5) sec = 5;
    end
    p = (v * (65536 - s)) >>> 16;
    q = (v * (65536 - ((s * f) >>> 16))) >>> 16;
    t = (v * (65536 - ((s * (65536 - f)) >>> 16))) >>> 16;
    case (sec)
      0: begin res.red = to_byte(v); res.green = to_byte(t); res.blue = to_byte(p); end
      1: begin res.red = to_byte(q); res.green = to_byte(v); res.blue = to_byte(p); end
      2: begin res.red = to_byte(p); res.green = to_byte(v); res.blue = to_byte(t); end
      3: begin res.red = to_byte(p); res.green = to_byte(q); res.blue = to_byte(v); end
      4: begin res.red = to_byte(t); res.green = to_byte(p); res.blue = to_byte(v); end
      default: begin
        res.red = to_byte(v); res.green = to_byte(p); res.blue = to_byte(q);
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  // Predict on every input transaction, compare on every output transaction
  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t want;
    if (!rst_ni) begin
      fail_count  = 0;
      blends_seen <= 0;
      expected_colours.delete();
      pending = 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        expected_colours.push_back(predict_blend(
          '{in_i.start_red, in_i.start_green, in_i.start_blue},
          '{in_i.end_red, in_i.end_green, in_i.end_blue}, in_i.blend_amount));
      end
      if (out_i.valid && out_i.ready) begin
        blends_seen <= blends_seen + 1;
        if (expected_colours.size() == 0) begin
          report_mismatch("result with no transaction outstanding");
        end else begin
          want = expected_colours.pop_front();
          if (out_i.out_red !== want.red)
            report_mismatch($sformatf("red %0d want %0d", out_i.out_red, want.red));
          if (out_i.out_green !== want.green)
            report_mismatch($sformatf("green %0d want %0d", out_i.out_green, want.green));
          if (out_i.out_blue !== want.blue)
            report_mismatch($sformatf("blue %0d want %0d", out_i.out_blue, want.blue));
        end
      end
      pending = expected_colours.size();
    end
  end
endmodule

>>> dv/tb.sv
// Testbench top for the HSV colour interpolator: stimulus, idling and verdict.
// Depends on the rtl interfaces and top level, hsvi_tb_pkg and hsvi_checker.
`timescale 1ns / 1ps
module tb;
  localparam int RandomBlends = 1400;
  localparam int CycleLimit   = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycle_count = 0;
  int   fail_count;
  int   pending;
  int   blends_seen;
  int   overdue;
  int   leftover;
  bit   quiet = 1'b0;

  hsvi_in_if  in_ch ();
  hsvi_out_if out_ch ();

  hsv_color_interpolator dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  hsvi_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_i(out_ch),
    .fail_count_o(fail_count), .pending_o(pending), .blends_seen_o(blends_seen)
  );

  always #4 clk_i = ~clk_i;

  // Hold the run to a generous cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stall the result side at random
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hsvi_tb_pkg::want_idle(quiet);
  end

  // Offer one transaction and hold it until accepted; valid stays up afterwards
  task automatic send_blend(logic [7:0] sr, sg, sb, er, eg, eb, amount);
    while (hsvi_tb_pkg::want_idle(quiet)) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.start_red    <= sr;
    in_ch.start_green  <= sg;
    in_ch.start_blue   <= sb;
    in_ch.end_red      <= er;
    in_ch.end_green    <= eg;
    in_ch.end_blue     <= eb;
    in_ch.blend_amount <= amount;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_component();
    case ($urandom_range(5, 0))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(3, 0));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_amount();
    case ($urandom_range(9, 0))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(2, 1));
      3: return 8'($urandom_range(254, 253));
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    logic [7:0] g;
    in_ch.valid = 1'b0;
    {in_ch.start_red, in_ch.start_green, in_ch.start_blue} = '0;
    {in_ch.end_red, in_ch.end_green, in_ch.end_blue, in_ch.blend_amount} = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: bypass weights, black, grey, each sector, negative hue blends
    send_blend(8'd10, 8'd20, 8'd30, 8'd200, 8'd100, 8'd50, 8'd0);
    send_blend(8'd10, 8'd20, 8'd30, 8'd200, 8'd100, 8'd50, 8'd255);
    send_blend(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd128);
    send_blend(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd1);
    send_blend(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd77);
    send_blend(8'd128, 8'd128, 8'd128, 8'd40, 8'd40, 8'd40, 8'd100);
    send_blend(8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd128);
    send_blend(8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd128);
    send_blend(8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd128);
    send_blend(8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd128);
    send_blend(8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd128);
    send_blend(8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd1, 8'd200);
    send_blend(8'd255, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd254);
    send_blend(8'd255, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1);
    send_blend(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254);
    send_blend(8'd1, 8'd0, 8'd0, 8'd255, 8'd254, 8'd253, 8'd170);
    in_ch.valid <= 1'b0;

    // Let everything drain before the random part
    while (pending != 0) @(negedge clk_i);

    // Random: components biased toward extremes and near-grey, some bursts unstalled
    for (int n = 0; n < RandomBlends; n++) begin
      quiet = (n >= 400 && n < 600);
      if ($urandom_range(7, 0) == 0) begin
        g = pick_component();
        send_blend(g, g, g, pick_component(), pick_component(), pick_component(),
                   pick_amount());
      end else begin
        send_blend(pick_component(), pick_component(), pick_component(),
                   pick_component(), pick_component(), pick_component(), pick_amount());
      end
    end
    in_ch.valid <= 1'b0;

    // Drain, then allow for the pipeline depth
    overdue = 0;
    while (pending != 0 && overdue < 5000) begin
      @(negedge clk_i);
      overdue++;
    end
    repeat (30) @(negedge clk_i);
    leftover = pending;

    $display("covered %0d blends: bypass weights, black, grey, all hue sectors, stalls",
             blends_seen);
    if (fail_count == 0 && leftover == 0) begin
      $display("status: pass");
    end else begin
      if (leftover != 0) $display("%0d results never arrived", leftover);
      $display("status: fail");
    end
    $finish;
  end
endmodule
